>>> hdl/lpa_pkg.sv
// Shared types, constants and register codes for the lag-0 power integration block.
package lpa_pkg;

    localparam int GATE_DEPTH_DEF    = 128;
    localparam int ATTEN_DIVISOR_DEF = 10;

    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 32;
    localparam int SUM_W       = 36;
    localparam int PWR_W       = 31;
    localparam int ACC_W       = 48;
    localparam int GATE_W      = 7;
    localparam int SCNT_W      = 4;
    localparam int SPR_W       = 5;
    localparam int RC_W        = 8;
    localparam int MAX_SAMPLES = 16;
    localparam int MAX_GATES   = 128;

    localparam int JOB_FIFO_DEPTH = 4;
    localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
    localparam int JOB_LVL_W      = $clog2(JOB_FIFO_DEPTH + 1);

    localparam int DIV_BITS = 8;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [PWR_W-1:0] PWR_MAX = '1;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    typedef enum logic [1:0] {
        REG_SAMPLES  = 2'd0,
        REG_RANGES   = 2'd1,
        REG_ATTEN    = 2'd2,
        REG_MIN_PEAK = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic                       accumulate;
    } t_in_item;

    typedef struct packed {
        logic [GATE_W-1:0] gate_index;
        logic [PWR_W-1:0]  gate_power;
        logic [ACC_W-1:0]  accumulated_power;
        logic              sequence_done;
        logic [GATE_W-1:0] peak_gate;
        logic              peak_valid;
    } t_result;

    typedef struct packed {
        logic [SPR_W-1:0] samples_per_range;
        logic [RC_W-1:0]  range_count;
        logic             atten_on;
        logic [PWR_W-1:0] min_peak_power;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0]  power_sum;
        logic [SPR_W-1:0]  n_samples;
        logic              accumulate;
        logic [GATE_W-1:0] gate;
        logic              last;
    } t_gate_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> hdl/lag0_power_accumulate_peak_select.sv
// Top level of the lag-0 power integration and peak range-gate selection block.
// Usage:
//   Samples enter as queue beats: one t_in_item is taken on each clock edge with
//   push high and full low; samples_per_range samples make one range gate and the
//   accumulate bit of a gate's last sample picks add (1) or overwrite (0).
//   Each completed gate yields one t_result beat on o_result while empty is low;
//   it leaves on an edge with pop high. The last gate of a sequence also carries
//   the peak gate and its valid flag.
// Rate and flow:
//   The front end takes one sample per cycle while full is low. Each finished gate
//   then holds the back end until its result is loaded: the pop, the wait on the
//   divider for the mean, a multiply for the attenuation step when it is on, then
//   update and output. Up to four finished gates wait in the job queue; intake
//   stops only when that queue fills.
// Reset and stall:
//   Synchronous reset restores the register defaults and clears the counters, the
//   partial sum, the queue and the peak search; accumulators stay undefined until
//   a gate overwrites them. If pop stays low the result register holds, the back
//   end parks with the next result, then the queue fills and full rises.
module lag0_power_accumulate_peak_select import lpa_pkg::*; #(
    parameter int GATE_DEPTH    = GATE_DEPTH_DEF,
    parameter int ATTEN_DIVISOR = ATTEN_DIVISOR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample queue
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    // result queue
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(GATE_DEPTH);

    t_cfg                 r_cfg;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    logic                 job_v;
    t_gate_job            job_in;
    t_gate_job            job_head;
    logic                 job_empty;
    logic                 job_pop;
    logic [JOB_LVL_W-1:0] job_level;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ACC_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ACC_W-1:0]     ram_rdata;

    logic                 div_start;
    logic [SUM_W-1:0]     div_num;
    logic [SPR_W-1:0]     div_den;
    t_div_stat            div_stat;
    logic [SUM_W-1:0]     div_quot;

    // Configuration registers: one word per register, written in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_range <= SPR_W'(1);
            r_cfg.range_count       <= RC_W'(75);
            r_cfg.atten_on          <= 1'b0;
            r_cfg.min_peak_power    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLES:  r_cfg.samples_per_range <= pwdata[SPR_W-1:0];
                REG_RANGES:   r_cfg.range_count       <= pwdata[RC_W-1:0];
                REG_ATTEN:    r_cfg.atten_on          <= pwdata[0];
                REG_MIN_PEAK: r_cfg.min_peak_power    <= pwdata[PWR_W-1:0];
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        unique case (reg_idx)
            REG_SAMPLES:  prdata = CFG_DATA_W'(r_cfg.samples_per_range);
            REG_RANGES:   prdata = CFG_DATA_W'(r_cfg.range_count);
            REG_ATTEN:    prdata = CFG_DATA_W'(r_cfg.atten_on);
            REG_MIN_PEAK: prdata = CFG_DATA_W'(r_cfg.min_peak_power);
        endcase
    end

    // Front end: per-sample power and the gate/sequence counters.
    lpa_front #(
        .GATE_DEPTH (GATE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_job_level (job_level),
        .o_job_v     (job_v),
        .o_job       (job_in)
    );

    // Finished gates wait here, so the sample side keeps moving while the back end works.
    lpa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_v),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_empty (job_empty),
        .o_level (job_level)
    );

    // Divider for the mean over the gate's samples.
    lpa_div #(
        .NUM_W (SUM_W),
        .DEN_W (SPR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Per-gate accumulators.
    lpa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (GATE_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Back end: mean, attenuation, accumulate, peak search, result register.
    lpa_back #(
        .GATE_DEPTH    (GATE_DEPTH),
        .ATTEN_DIVISOR (ATTEN_DIVISOR)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_div_start (div_start),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_stat  (div_stat),
        .i_div_quot  (div_quot),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    // A finished gate must always find room in the job queue.
    a_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_v |-> (job_level < JOB_FIFO_DEPTH))
        else $error("job queue overflow");

    // Never restart the divider while it is still working.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // Accumulator read and write never share a cycle.
    a_ram_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("accumulator read and write collide");

    // Peak fields stay clear on gates that do not end a sequence.
    a_peak_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.sequence_done) |->
            ((o_result.peak_gate == '0) && !o_result.peak_valid))
        else $error("peak fields set on a mid-sequence gate");

endmodule

>>> hdl/lpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lpa_div.sv
// Iterative unsigned divider, DIV_BITS quotient bits per cycle.
module lpa_div import lpa_pkg::*; #(
    parameter int NUM_W = SUM_W,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W = STEPS * DIV_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [PAD_W-1:0] r_work;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W-1:0] n_rem;
    logic [PAD_W-1:0] n_work;
    logic [DEN_W:0]   trial;

    // Restoring division: shift a dividend bit into the remainder, subtract when it fits.
    always_comb begin
        n_rem  = r_rem;
        n_work = r_work;
        trial  = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial  = {n_rem, n_work[PAD_W-1]};
            n_work = {n_work[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial     = trial - {1'b0, r_den};
                n_work[0] = 1'b1;
            end
            n_rem = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
                r_rem  <= '0;
                r_work <= PAD_W'(i_num);
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_work <= n_work;
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_work[NUM_W-1:0];

endmodule

>>> hdl/lpa_fifo.sv
// Short job queue between the sample front end and the gate back end.
module lpa_fifo import lpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_gate_job            i_data,
    input  logic                 i_pop,
    output t_gate_job            o_head,
    output logic                 o_empty,
    output logic [JOB_LVL_W-1:0] o_level
);

    t_gate_job              r_mem [JOB_FIFO_DEPTH];
    logic [JOB_PTR_W-1:0]   r_wptr;
    logic [JOB_PTR_W-1:0]   r_rptr;
    logic [JOB_LVL_W-1:0]   r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= r_wptr + JOB_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + JOB_PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_level <= r_level + JOB_LVL_W'(1);
                2'b01:   r_level <= r_level - JOB_LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

>>> hdl/lpa_front.sv
// Front end: takes samples, sums I^2+Q^2 per gate, hands finished gates to the job queue.
module lpa_front import lpa_pkg::*; #(
    parameter int GATE_DEPTH = GATE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    input  logic [JOB_LVL_W-1:0] i_job_level,
    output logic                 o_job_v,
    output t_gate_job            o_job
);

    localparam int GATE_LIM = (GATE_DEPTH < MAX_GATES) ? GATE_DEPTH : MAX_GATES;

    logic [SCNT_W-1:0] r_scnt;
    logic [GATE_W-1:0] r_gcnt;
    logic [SUM_W-1:0]  r_sum;
    logic              r_v;
    logic              r_done;
    logic [SQ_W-1:0]   r_pwr;
    logic              r_acc;
    logic [GATE_W-1:0] r_gate;
    logic              r_last;
    logic [SPR_W-1:0]  r_n;

    logic [SPR_W-1:0]       n_eff;
    logic [RC_W-1:0]        g_eff;
    logic                   accept;
    logic                   complete;
    logic                   last_gate;
    logic signed [SQ_W-1:0] prod_i;
    logic signed [SQ_W-1:0] prod_q;
    logic [SQ_W-1:0]        pwr;
    logic [SUM_W-1:0]       sum_next;
    logic [JOB_LVL_W:0]     occ;

    always_comb begin
        if (i_cfg.samples_per_range == '0) begin
            n_eff = SPR_W'(1);
        end else if (i_cfg.samples_per_range > SPR_W'(MAX_SAMPLES)) begin
            n_eff = SPR_W'(MAX_SAMPLES);
        end else begin
            n_eff = i_cfg.samples_per_range;
        end
        if (i_cfg.range_count == '0) begin
            g_eff = RC_W'(1);
        end else if (i_cfg.range_count > RC_W'(GATE_LIM)) begin
            g_eff = RC_W'(GATE_LIM);
        end else begin
            g_eff = i_cfg.range_count;
        end
    end

    assign complete  = (SPR_W'(r_scnt) + SPR_W'(1)) >= n_eff;
    assign last_gate = (RC_W'(r_gcnt) + RC_W'(1)) >= g_eff;

    assign prod_i = i_item.i_sample * i_item.i_sample;
    assign prod_q = i_item.q_sample * i_item.q_sample;
    assign pwr    = unsigned'(prod_i) + unsigned'(prod_q);

    // Hold off when the queue cannot take the job that is already on its way.
    assign occ    = {1'b0, i_job_level} + (JOB_LVL_W + 1)'(r_v & r_done);
    assign full   = occ >= (JOB_LVL_W + 1)'(JOB_FIFO_DEPTH);
    assign accept = push & ~full;

    assign sum_next = r_sum + SUM_W'(r_pwr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
            r_gcnt <= '0;
            r_sum  <= '0;
            r_v    <= 1'b0;
        end else begin
            r_v <= accept;
            if (accept) begin
                r_scnt <= complete ? '0 : r_scnt + SCNT_W'(1);
                if (complete) begin
                    r_gcnt <= last_gate ? '0 : r_gcnt + GATE_W'(1);
                end
                r_pwr  <= pwr;
                r_done <= complete;
                r_acc  <= i_item.accumulate;
                r_gate <= r_gcnt;
                r_last <= last_gate;
                r_n    <= n_eff;
            end
            if (r_v) begin
                r_sum <= r_done ? '0 : sum_next;
            end
        end
    end

    assign o_job_v = r_v & r_done;
    assign o_job   = '{power_sum:  sum_next,
                       n_samples:  r_n,
                       accumulate: r_acc,
                       gate:       r_gate,
                       last:       r_last};

endmodule

>>> hdl/lpa_back.sv
// Back end: mean, attenuation, accumulator update, peak tracking and the result register.
module lpa_back import lpa_pkg::*; #(
    parameter int GATE_DEPTH    = GATE_DEPTH_DEF,
    parameter int ATTEN_DIVISOR = ATTEN_DIVISOR_DEF,
    localparam int ADDR_W = $clog2(GATE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_job_empty,
    input  t_gate_job         i_job,
    output logic              o_job_pop,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [ACC_W-1:0]  o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [ACC_W-1:0]  i_ram_rdata,
    output logic              o_div_start,
    output logic [SUM_W-1:0]  o_div_num,
    output logic [SPR_W-1:0]  o_div_den,
    input  t_div_stat         i_div_stat,
    input  logic [SUM_W-1:0]  i_div_quot,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result
);

    // Attenuation by reciprocal multiplication: the reciprocal is rounded up, which
    // gives the exact floor quotient for every 31-bit mean.
    localparam int RCP_W     = 33;
    localparam int ATT_SHIFT = PWR_W + $clog2(ATTEN_DIVISOR);
    localparam logic [RCP_W-1:0] ATT_RCP =
        RCP_W'(((64'd1 << ATT_SHIFT) + 64'(ATTEN_DIVISOR) - 64'd1) / 64'(ATTEN_DIVISOR));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ATT,
        S_UPD,
        S_OUT
    } t_state;

    t_state            r_state;
    logic              r_acc;
    logic [GATE_W-1:0] r_gate;
    logic              r_last;
    logic [PWR_W-1:0]  r_mean;
    logic [ACC_W-1:0]  r_best_acc;
    logic [GATE_W-1:0] r_best_gate;
    logic [PWR_W-1:0]  r_best_pwr;
    t_result           r_res;
    logic              r_out_v;
    t_result           r_out;

    logic [PWR_W-1:0]       mean_sat;
    logic [PWR_W+RCP_W-1:0] att_prod;
    logic [PWR_W-1:0]       att_quot;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_new;
    logic                   take;
    logic [ACC_W-1:0]       n_best_acc;
    logic [GATE_W-1:0]      n_best_gate;
    logic [PWR_W-1:0]       n_best_pwr;
    logic                   out_take;
    logic                   out_load;
    t_result                res;

    assign mean_sat = (|i_div_quot[SUM_W-1:PWR_W]) ? PWR_MAX : i_div_quot[PWR_W-1:0];

    assign att_prod = r_mean * ATT_RCP;
    assign att_quot = PWR_W'(att_prod >> ATT_SHIFT);

    always_comb begin
        acc_sum = {1'b0, i_ram_rdata} + (ACC_W + 1)'(r_mean);
        if (r_acc) begin
            acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        end else begin
            acc_new = ACC_W'(r_mean);
        end
        // Gate zero restarts the search; a tie keeps the earlier gate.
        take        = (r_gate == '0) || (acc_new > r_best_acc);
        n_best_acc  = take ? acc_new : r_best_acc;
        n_best_gate = take ? r_gate  : r_best_gate;
        n_best_pwr  = take ? r_mean  : r_best_pwr;
        res = '{gate_index:        r_gate,
                gate_power:        r_mean,
                accumulated_power: acc_new,
                sequence_done:     r_last,
                peak_gate:         r_last ? n_best_gate : '0,
                peak_valid:        r_last && (n_best_pwr >= i_cfg.min_peak_power)};
    end

    assign o_job_pop   = (r_state == S_IDLE) && !i_job_empty;
    assign o_div_start = o_job_pop;
    assign o_div_num   = i_job.power_sum;
    assign o_div_den   = i_job.n_samples;
    assign o_ram_re    = o_job_pop;
    assign o_ram_raddr = ADDR_W'(i_job.gate);
    assign o_ram_we    = (r_state == S_UPD);
    assign o_ram_waddr = ADDR_W'(r_gate);
    assign o_ram_wdata = acc_new;

    assign out_take = pop && r_out_v;
    assign out_load = (r_state == S_OUT) && (!r_out_v || out_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_v     <= 1'b0;
            r_best_acc  <= '0;
            r_best_gate <= '0;
            r_best_pwr  <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_acc   <= i_job.accumulate;
                        r_gate  <= i_job.gate;
                        r_last  <= i_job.last;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_div_stat.done) begin
                        r_mean  <= mean_sat;
                        r_state <= i_cfg.atten_on ? S_ATT : S_UPD;
                    end
                end
                S_ATT: begin
                    r_mean  <= att_quot;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_best_acc  <= n_best_acc;
                    r_best_gate <= n_best_gate;
                    r_best_pwr  <= n_best_pwr;
                    r_res       <= res;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty    = !r_out_v;
    assign o_result = r_out;

endmodule

>>> sim/lag0_power_accumulate_peak_select_test.sv
// Self-checking testbench for the lag-0 power integration and peak gate select block.
module lag0_power_accumulate_peak_select_test;
    import lpa_pkg::*;

    // Random part size, and the quiet time allowed after the last result for
    // a gate still in the back end.
    localparam int unsigned RANDOM_SAMPLES = 1250;
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam longint unsigned ATTEN_DIV  = ATTEN_DIVISOR_DEF;

    // Sample mixes for the random part: full range, tiny levels that give
    // peak ties, the extreme codes, and mostly zero.
    typedef enum int unsigned {
        LEVEL_FULL,
        LEVEL_SMALL,
        LEVEL_EDGE,
        LEVEL_SPARSE
    } t_level_mix;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lag0_power_accumulate_peak_select DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Power predictor: its own copy of the registers and of the gate state.
    // ------------------------------------------------------------------
    logic [SPR_W-1:0]  cfg_samples;
    logic [RC_W-1:0]   cfg_gates;
    logic              cfg_atten;
    logic [PWR_W-1:0]  cfg_min_peak;

    logic [ACC_W-1:0]  gate_acc  [MAX_GATES];
    bit                gate_live [MAX_GATES];   // set once a gate has been overwritten
    int unsigned       sample_pos;
    int unsigned       gate_pos;
    logic [SUM_W-1:0]  energy_sum;
    logic [ACC_W-1:0]  peak_acc;
    logic [GATE_W-1:0] peak_idx;
    logic [PWR_W-1:0]  peak_power;

    t_result     gate_results_due [$];
    int unsigned mismatch_count;
    int unsigned random_sent;
    bit          no_idle;   // both sides run without gaps while set

    // Clamp the sample count to 1..16 and the gate count to 1..128.
    function automatic int unsigned samples_in_force();
        if (cfg_samples == 0) return 1;
        if (cfg_samples > MAX_SAMPLES) return MAX_SAMPLES;
        return 32'(cfg_samples);
    endfunction

    function automatic int unsigned gates_in_force();
        if (cfg_gates == 0) return 1;
        if (cfg_gates > MAX_GATES) return MAX_GATES;
        return 32'(cfg_gates);
    endfunction

    // True when the next beat closes a gate whose accumulator holds nothing yet.
    function automatic bit closes_fresh_gate();
        return (sample_pos + 1 >= samples_in_force()) && !gate_live[gate_pos];
    endfunction

    function automatic void apply_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SAMPLES:  cfg_samples  = value[SPR_W-1:0];
            REG_RANGES:   cfg_gates    = value[RC_W-1:0];
            REG_ATTEN:    cfg_atten    = value[0];
            REG_MIN_PEAK: cfg_min_peak = value[PWR_W-1:0];
            default: ;
        endcase
    endfunction

    // Fold one accepted sample into the gate sum; on a gate's last sample
    // derive the mean, update the accumulator and the peak search, and queue
    // the expected result beat.
    function automatic void absorb_sample(t_in_item it);
        longint          re;
        longint          im;
        longint unsigned mean;
        longint unsigned total;
        int unsigned     n;
        bit              last;
        t_result         r;
        re = $signed(it.i_sample);
        im = $signed(it.q_sample);
        n  = samples_in_force();
        energy_sum = SUM_W'(energy_sum + (re * re + im * im));
        if (sample_pos + 1 < n) begin
            sample_pos = (sample_pos + 1) % MAX_SAMPLES;
            return;
        end
        sample_pos = 0;
        mean = energy_sum / n;
        energy_sum = '0;
        if (mean > PWR_MAX) mean = PWR_MAX;
        if (cfg_atten) mean = mean / ATTEN_DIV;
        if (it.accumulate) begin
            total = gate_acc[gate_pos] + mean;
            if (total > ACC_MAX) total = ACC_MAX;
        end else begin
            total = mean;
        end
        gate_acc[gate_pos]  = ACC_W'(total);
        gate_live[gate_pos] = 1'b1;
        // Restart the search on gate 0; later gates win only when strictly larger.
        if (gate_pos == 0 || total > peak_acc) begin
            peak_acc   = ACC_W'(total);
            peak_idx   = GATE_W'(gate_pos);
            peak_power = PWR_W'(mean);
        end
        last = (gate_pos + 1 >= gates_in_force());
        r.gate_index        = GATE_W'(gate_pos);
        r.gate_power        = PWR_W'(mean);
        r.accumulated_power = ACC_W'(total);
        r.sequence_done     = last;
        r.peak_gate         = last ? peak_idx : '0;
        r.peak_valid        = last && (peak_power >= cfg_min_peak);
        gate_results_due.push_back(r);
        gate_pos = last ? 0 : (gate_pos + 1) % MAX_GATES;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(t_result got);
        t_result want;
        if (gate_results_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat expected none actual gate %0d", $time, got.gate_index);
            return;
        end
        want = gate_results_due.pop_front();
        compare_field("gate_index", 64'(want.gate_index), 64'(got.gate_index));
        compare_field("gate_power", 64'(want.gate_power), 64'(got.gate_power));
        compare_field("accumulated_power", 64'(want.accumulated_power),
                      64'(got.accumulated_power));
        compare_field("sequence_done", 64'(want.sequence_done), 64'(got.sequence_done));
        compare_field("peak_gate", 64'(want.peak_gate), 64'(got.peak_gate));
        compare_field("peak_valid", 64'(want.peak_valid), 64'(got.peak_valid));
    endfunction

    // Drain results: hold pop low for a random stretch, then take one beat.
    initial begin : result_drain
        int unsigned hold;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_result(o_result);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Drivers: called at a falling edge, they return at a falling edge.
    // ------------------------------------------------------------------
    function automatic t_in_item make_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im,
                                             logic add);
        t_in_item it;
        it.i_sample   = re;
        it.q_sample   = im;
        it.accumulate = add;
        return it;
    endfunction

    // Send one sample beat after a random gap; never add into an empty gate.
    task automatic push_sample(input t_in_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (closes_fresh_gate()) it.accumulate = 1'b0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        absorb_sample(it);
        @(negedge i_clk);
    endtask

    // Drop push, wait out every expected beat, then let the back end go quiet.
    task automatic wait_idle();
        push <= 1'b0;
        while (gate_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then psel drops so writes never abut.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_level(t_level_mix mix);
        case (mix)
            LEVEL_FULL:  return SAMPLE_W'($urandom);
            LEVEL_SMALL: return SAMPLE_W'($urandom_range(0, 6) - 3);
            LEVEL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    3:       return 16'h0000;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
            default: begin
                if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom_range(0, 2) - 1);
                return '0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: one sample per gate, 75 gates. Hit the field extremes,
    // including a beat with both components full-scale negative that overflows the mean.
    task automatic test_reset_defaults();
        push_sample(make_sample(16'h7FFF, 16'h7FFF, 1'b1));
        push_sample(make_sample(16'h8000, 16'h8000, 1'b0));
        push_sample(make_sample(16'h0000, 16'h0000, 1'b1));
        push_sample(make_sample(16'hFFFF, 16'h0001, 1'b0));
        push_sample(make_sample(16'h1234, 16'hEDCB, 1'b1));
        wait_idle();
    endtask

    // Shrink the gate count below the current gate: the next gate ends the
    // sequence, then a short sequence integrates on top of the first pass.
    task automatic test_sequence_cutoff();
        write_reg(REG_RANGES, 3);
        push_sample(make_sample(16'd100, 16'd0, 1'b1));
        push_sample(make_sample(16'd7, 16'hFFF0, 1'b1));
        push_sample(make_sample(16'h4000, 16'h4000, 1'b1));
        push_sample(make_sample(16'd1, 16'd1, 1'b1));
        wait_idle();
    endtask

    // Saturated mean with the threshold at its top: valid without attenuation,
    // invalid once the attenuation step divides the power down.
    task automatic test_mean_saturation();
        write_reg(REG_SAMPLES, 2);
        write_reg(REG_RANGES, 1);
        write_reg(REG_MIN_PEAK, PWR_MAX);
        push_sample(make_sample(16'h8000, 16'h8000, 1'b0));
        push_sample(make_sample(16'h8000, 16'h8000, 1'b0));
        wait_idle();
        write_reg(REG_ATTEN, 1);
        push_sample(make_sample(16'h8000, 16'h8000, 1'b1));
        push_sample(make_sample(16'h8000, 16'h8000, 1'b1));
        wait_idle();
    endtask

    // All gates zero: peak stays on gate 0. Then a tie: the first of two
    // equal gates wins, and its power sits below the threshold.
    task automatic test_flat_power();
        write_reg(REG_SAMPLES, 1);
        write_reg(REG_RANGES, 3);
        write_reg(REG_ATTEN, 0);
        write_reg(REG_MIN_PEAK, 0);
        repeat (3) push_sample(make_sample(16'd0, 16'd0, 1'b0));
        wait_idle();
        write_reg(REG_MIN_PEAK, 5);
        push_sample(make_sample(16'd1, 16'd0, 1'b0));
        push_sample(make_sample(16'd2, 16'd0, 1'b0));
        push_sample(make_sample(16'd0, 16'hFFFE, 1'b0));
        wait_idle();
    endtask

    // Change the sample count in the middle of a gate: the gate closes as soon
    // as its position reaches the new count. A count of zero acts as one.
    task automatic test_mid_gate_change();
        write_reg(REG_SAMPLES, 4);
        write_reg(REG_RANGES, 2);
        push_sample(make_sample(16'd3, 16'd4, 1'b1));
        push_sample(make_sample(16'd5, 16'd12, 1'b1));
        wait_idle();
        write_reg(REG_SAMPLES, 2);
        push_sample(make_sample(16'd8, 16'd15, 1'b1));
        wait_idle();
        write_reg(REG_SAMPLES, 0);
        push_sample(make_sample(16'd1, 16'hFFFF, 1'b1));
        wait_idle();
    endtask

    // Phases of whole sequences under random settings, mostly integrating,
    // some left with a partial gate so the next setting lands mid-gate.
    task automatic test_random_sequences();
        int unsigned phase_len;
        int unsigned acc_odds;
        int unsigned pick;
        t_level_mix  mix;
        t_in_item    it;
        while (random_sent < RANDOM_SAMPLES) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            case (pick)
                0:       write_reg(REG_SAMPLES, 0);
                1, 2:    write_reg(REG_SAMPLES, MAX_SAMPLES);
                3:       write_reg(REG_SAMPLES, $urandom_range(17, 31));
                default: write_reg(REG_SAMPLES, $urandom_range(1, 4));
            endcase
            pick = $urandom_range(0, 19);
            case (pick)
                0:       write_reg(REG_RANGES, 0);
                1:       write_reg(REG_RANGES, MAX_GATES);
                2:       write_reg(REG_RANGES, $urandom_range(129, 255));
                3:       write_reg(REG_RANGES, $urandom_range(13, 127));
                default: write_reg(REG_RANGES, $urandom_range(1, 12));
            endcase
            write_reg(REG_ATTEN, $urandom);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_MIN_PEAK, 0);
                1:       write_reg(REG_MIN_PEAK, 32'hFFFF_FFFF);
                2:       write_reg(REG_MIN_PEAK, $urandom);
                default: write_reg(REG_MIN_PEAK, $urandom_range(0, 20));
            endcase
            mix      = t_level_mix'($urandom_range(0, 3));
            acc_odds = ($urandom_range(0, 3) == 0) ? 5 : 9;
            no_idle  = ($urandom_range(0, 4) == 0);
            phase_len = samples_in_force() * gates_in_force() * $urandom_range(1, 3);
            if (phase_len > 300) phase_len = 300;
            if ($urandom_range(0, 3) == 0)
                phase_len += $urandom_range(1, 2 * samples_in_force());
            repeat (phase_len) begin
                it.i_sample   = draw_level(mix);
                it.q_sample   = draw_level(mix);
                it.accumulate = ($urandom_range(0, 9) < acc_odds);
                push_sample(it);
                random_sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        random_sent    = 0;
        // Predictor starts from the register defaults and cleared counters.
        cfg_samples  = 1;
        cfg_gates    = 75;
        cfg_atten    = 1'b0;
        cfg_min_peak = '0;
        sample_pos   = 0;
        gate_pos     = 0;
        energy_sum   = '0;
        peak_acc     = '0;
        peak_idx     = '0;
        peak_power   = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_sequence_cutoff();
        test_mean_saturation();
        test_flat_power();
        test_mid_gate_change();
        test_random_sequences();

        wait_idle();
        if (mismatch_count == 0 && gate_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop, several times the slowest legal run.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
